// ===== rtl/depq_pkg.sv =====
// Shared types, codes and defaults for the double-ended priority queue.
package depq_pkg;

   localparam int DEFAULT_CAPACITY      = 16;
   localparam int DEFAULT_PRIORITY_BITS = 16;

   localparam int ITEM_W     = 32;
   localparam int REQ_PRIO_W = 16;
   localparam int RSP_CNT_W  = 5;

   typedef enum logic [1:0] {
      CMD_INSERT     = 2'd0,
      CMD_REMOVE_MAX = 2'd1,
      CMD_REMOVE_MIN = 2'd2,
      CMD_CLEAR      = 2'd3
   } depq_cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } depq_status_type;

   typedef struct packed {
      depq_cmd_type             command;
      logic signed [ITEM_W-1:0] item_value;
      logic [REQ_PRIO_W-1:0]    priority_req;
   } depq_req_type;

   typedef struct packed {
      depq_status_type          status;
      logic signed [ITEM_W-1:0] removed_item;
      logic [RSP_CNT_W-1:0]     count;
   } depq_rsp_type;

endpackage

// ===== rtl/double_ended_priority_queue_core.sv =====
// Double-ended priority queue: sorted ring in one synchronous memory.
// Refused commands and clear strobe the result in the cycle after the transfer; removals
// pass through ST_REMOVE first. An insert alternates ST_INS_RD and ST_INS_CMP, shifting
// entries one place towards the tail, until it reaches the head or stops short.
// Throughput: one command at a time; busy is low again in the cycle of the strobe.
// The receiver cannot stall. Synchronous reset empties the queue; memory is left as is.
module double_ended_priority_queue_core
   import depq_pkg::*;
#(
   parameter int CAPACITY      = DEFAULT_CAPACITY,
   parameter int PRIORITY_BITS = DEFAULT_PRIORITY_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  depq_req_type req_payload,
   output logic         rsp_valid,
   output depq_rsp_type rsp_payload
);

   localparam int AW     = $clog2(CAPACITY);
   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int PRIO_W = (PRIORITY_BITS < REQ_PRIO_W) ? PRIORITY_BITS : REQ_PRIO_W;
   localparam int ENT_W  = ITEM_W + PRIO_W;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_INS_RD  = 4'b0010,
      ST_INS_CMP = 4'b0100,
      ST_REMOVE  = 4'b1000
   } state_type;

   // logical position k from the head, mapped into the ring
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                          input logic [CW-1:0] k);
      logic [AW+1:0] s;
      s = {2'b00, base} + {{(AW+2-CW){1'b0}}, k};
      if (s >= (AW+2)'(CAPACITY)) begin
         s = s - (AW+2)'(CAPACITY);
      end
      return s[AW-1:0];
   endfunction

   logic [ENT_W-1:0] mem [CAPACITY];
   logic [ENT_W-1:0] rd_data_ff;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [ENT_W-1:0] wr_data;

   state_type        state_ff, state_in;
   logic [AW-1:0]    head_ff, head_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    hole_ff, hole_in;
   logic [ENT_W-1:0] new_ff, new_in;
   logic             max_ff, max_in;
   logic             rsp_valid_ff, rsp_valid_in;
   depq_rsp_type     rsp_ff, rsp_in;

   logic [CW+RSP_CNT_W-1:0] count_wide;
   logic                    accept;
   logic                    full;
   logic                    empty;
   logic [PRIO_W-1:0]       rd_prio;

   assign accept  = start & state_ff[0];
   assign full    = (count_ff == CW'(CAPACITY));
   assign empty   = (count_ff == '0);
   assign rd_prio = rd_data_ff[PRIO_W-1:0];
   assign count_wide = {{RSP_CNT_W{1'b0}}, count_in};

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      hole_in      = hole_ff;
      new_in       = new_ff;
      max_in       = max_ff;
      rsp_valid_in = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      wr_en        = 1'b0;
      wr_addr      = head_ff;
      wr_data      = new_ff;
      rsp_in.status       = STATUS_OK;
      rsp_in.removed_item = '0;
      rsp_in.count        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_payload.command)
                  CMD_INSERT: begin
                     if (full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        new_in   = {req_payload.item_value,
                                    req_payload.priority_req[PRIO_W-1:0]};
                        hole_in  = count_ff;
                        state_in = ST_INS_RD;
                     end
                  end
                  CMD_REMOVE_MAX, CMD_REMOVE_MIN: begin
                     if (empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        max_in   = (req_payload.command == CMD_REMOVE_MAX);
                        rd_addr  = (req_payload.command == CMD_REMOVE_MAX) ? head_ff :
                                   phys(head_ff, count_ff - CW'(1));
                        state_in = ST_REMOVE;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_INS_RD: begin
            if (hole_ff == '0) begin
               // reached the head: new entry outranks everything held
               wr_en        = 1'b1;
               wr_addr      = head_ff;
               count_in     = count_ff + CW'(1);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = phys(head_ff, hole_ff - CW'(1));
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            wr_en   = 1'b1;
            wr_addr = phys(head_ff, hole_ff);
            // equal priority moves back, so the newer entry sits nearer the head
            if (rd_prio <= new_ff[PRIO_W-1:0]) begin
               wr_data  = rd_data_ff;
               hole_in  = hole_ff - CW'(1);
               state_in = ST_INS_RD;
            end else begin
               count_in     = count_ff + CW'(1);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_REMOVE: begin
            count_in            = count_ff - CW'(1);
            rsp_valid_in        = 1'b1;
            rsp_in.removed_item = rd_data_ff[ENT_W-1 -: ITEM_W];
            if (max_ff) begin
               head_in = phys(head_ff, CW'(1));
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_in.count = count_wide[RSP_CNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         hole_ff      <= '0;
         max_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         hole_ff      <= hole_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      new_ff <= new_in;
      rsp_ff <= rsp_in;
   end

   assign busy        = ~state_ff[0];
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the double-ended priority queue core.
module tb_top;
   import depq_pkg::*;

   localparam int DEPTH        = DEFAULT_CAPACITY;
   localparam int CYCLE_LIMIT  = 1000000;
   // margin for the longest insert, which shifts every entry already held
   localparam int DRAIN_CYCLES = 2 + 2 * DEPTH + 8;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   logic         rsp_valid;
   depq_req_type req;
   depq_rsp_type rsp;

   // predicted queue contents, highest priority at the front
   logic signed [ITEM_W-1:0] held_item[$];
   logic [REQ_PRIO_W-1:0]    held_prio[$];
   depq_rsp_type             pending_rsp[$];

   int errors   = 0;
   int cycles   = 0;
   int idle_pct = 0;

   double_ended_priority_queue_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // Applies one command to the shadow queue and returns the result it should give.
   function automatic depq_rsp_type predict_queue_result(depq_req_type r);
      depq_rsp_type res;
      int           pos;
      res.status       = STATUS_OK;
      res.removed_item = '0;
      case (r.command)
         CMD_INSERT: begin
            if (held_item.size() >= DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               // new entry goes ahead of equal priorities
               pos = 0;
               while (pos < held_prio.size() && held_prio[pos] > r.priority_req) pos++;
               held_item.insert(pos, r.item_value);
               held_prio.insert(pos, r.priority_req);
            end
         end
         CMD_REMOVE_MAX: begin
            if (held_item.size() == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.removed_item = held_item.pop_front();
               void'(held_prio.pop_front());
            end
         end
         CMD_REMOVE_MIN: begin
            if (held_item.size() == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.removed_item = held_item.pop_back();
               void'(held_prio.pop_back());
            end
         end
         default: begin
            held_item.delete();
            held_prio.delete();
         end
      endcase
      res.count = RSP_CNT_W'(held_item.size());
      return res;
   endfunction

   // Drives one command, optionally after a random gap, and waits for its transfer.
   task automatic send_command(input depq_cmd_type cmd,
                               input logic signed [ITEM_W-1:0] value,
                               input logic [REQ_PRIO_W-1:0] prio);
      depq_req_type r;
      r.command      = cmd;
      r.item_value   = value;
      r.priority_req = prio;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start <= 1'b1;
      req   <= r;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(predict_queue_result(r));
   endtask

   always @(posedge clock) begin : rsp_check
      depq_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result status %0d item %0d count %0d", $time,
                     rsp.status, rsp.removed_item, rsp.count);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp.status);
               errors++;
            end
            if (rsp.removed_item !== want.removed_item) begin
               $display("%0t: removed_item expected %0d actual %0d", $time,
                        want.removed_item, rsp.removed_item);
               errors++;
            end
            if (rsp.count !== want.count) begin
               $display("%0t: count expected %0d actual %0d", $time, want.count, rsp.count);
               errors++;
            end
         end
      end
   end

   task automatic test_empty_removals();
      send_command(CMD_REMOVE_MAX, 32'h1234_5678, 16'hFFFF);
      send_command(CMD_REMOVE_MIN, 32'hFFFF_FFFF, 16'h0000);
      send_command(CMD_CLEAR, 32'h0, 16'h0);
   endtask

   // Sixteen inserts with extreme values and tied priorities, then one refused.
   task automatic test_fill_to_full();
      logic signed [ITEM_W-1:0] value;
      logic [REQ_PRIO_W-1:0]    prio;
      for (int k = 0; k <= DEPTH; k++) begin
         case (k)
            0:       value = 32'h8000_0000;
            1:       value = 32'h7FFF_FFFF;
            2:       value = 32'h0000_0000;
            3:       value = 32'hFFFF_FFFF;
            4:       value = 32'h5555_5555;
            5:       value = 32'hAAAA_AAAA;
            default: value = $urandom;
         endcase
         case (k % 4)
            0:       prio = 16'h0000;
            1:       prio = 16'hFFFF;
            default: prio = 16'h8000;
         endcase
         send_command(CMD_INSERT, value, prio);
      end
   endtask

   task automatic test_remove_and_clear();
      send_command(CMD_REMOVE_MAX, $urandom, REQ_PRIO_W'($urandom));
      send_command(CMD_REMOVE_MIN, $urandom, REQ_PRIO_W'($urandom));
      send_command(CMD_CLEAR, $urandom, REQ_PRIO_W'($urandom));
   endtask

   // Mix biased in turn towards filling and draining so both ends are reached often.
   task automatic test_random_traffic(input int n_items, input int idle);
      int                    insert_bias;
      int                    pick;
      depq_cmd_type          cmd;
      logic [REQ_PRIO_W-1:0] prio;
      idle_pct    = idle;
      insert_bias = 50;
      for (int i = 0; i < n_items; i++) begin
         if (i % 40 == 0) insert_bias = 20 + 30 * $urandom_range(2);
         pick = $urandom_range(99);
         if (pick < 3) cmd = CMD_CLEAR;
         else if (pick < insert_bias) cmd = CMD_INSERT;
         else if ($urandom_range(1) == 1) cmd = CMD_REMOVE_MAX;
         else cmd = CMD_REMOVE_MIN;
         case ($urandom_range(3))
            0:       prio = REQ_PRIO_W'($urandom_range(3));   // dense ties
            1:       prio = ($urandom_range(1) == 1) ? 16'hFFFF : 16'h0000;
            default: prio = REQ_PRIO_W'($urandom);
         endcase
         send_command(cmd, $urandom, prio);
      end
   endtask

   // Sender holds off until every outstanding result has arrived.
   task automatic test_pause_until_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      idle_pct = 20;
      test_empty_removals();
      test_fill_to_full();
      test_remove_and_clear();
      test_random_traffic(600, 20);
      test_pause_until_drained();
      test_random_traffic(600, 88);
      test_pause_until_drained();
      test_random_traffic(600, 0);
      test_pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
